// ===== rtl/xmlp_pkg.sv =====
// Package for the extended-module length parser.
// Shared types and constants; no dependencies.
package xmlp_pkg;

  localparam int unsigned HDR_BYTES     = 336;
  localparam int unsigned PAT_HDR_BYTES = 9;
  localparam int unsigned SIG_LEN       = 17;

  typedef enum logic [1:0] {
    ST_STRONG    = 2'd0,
    ST_WEAK      = 2'd1,
    ST_REJECTED  = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  // byte request handed from the front end to the parse engine
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
  } byte_req_t;

  // verdict handed from the parse engine to the output stage
  typedef struct packed {
    status_t     status;
    logic [31:0] total_length;
  } verdict_t;

  function automatic logic [7:0] sig_char(input logic [4:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0:  c = 8'h45; // E
      5'd1:  c = 8'h78; // x
      5'd2:  c = 8'h74; // t
      5'd3:  c = 8'h65; // e
      5'd4:  c = 8'h6e; // n
      5'd5:  c = 8'h64; // d
      5'd6:  c = 8'h65; // e
      5'd7:  c = 8'h64; // d
      5'd8:  c = 8'h20;
      5'd9:  c = 8'h4d; // M
      5'd10: c = 8'h6f; // o
      5'd11: c = 8'h64; // d
      5'd12: c = 8'h75; // u
      5'd13: c = 8'h6c; // l
      5'd14: c = 8'h65; // e
      5'd15: c = 8'h3a; // :
      5'd16: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/xmlp_front.sv =====
// Input front end: skid-buffered byte queue (two entries).
// Depends on xmlp_pkg.
module xmlp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  xmlp_pkg::byte_req_t in_req,
  output logic                q_valid,
  input  logic                q_ready,
  output xmlp_pkg::byte_req_t q_req
);

  xmlp_pkg::byte_req_t mem [2];
  logic [1:0] count;
  logic       rd_ptr, wr_ptr;
  logic       push, pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_req    = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_req;
    end
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overfill");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd2) |-> !in_ready)
    else $error("ready while full");
  assert property (@(posedge clk) disable iff (rst)
                   (count == 2'd0 && !push) |=> !q_valid)
    else $error("phantom entry");

endmodule

// ===== rtl/xmlp_engine.sv =====
// Parse engine: walks headers and data, one byte per cycle while no held verdict stalls it.
// Depends on xmlp_pkg.
module xmlp_engine #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  xmlp_pkg::byte_req_t q_req,
  output logic                v_valid,
  input  logic                v_ready,
  output xmlp_pkg::verdict_t  v_out
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_PAT_HDR, PH_PAT_DATA, PH_INS_HDR, PH_SMP_HDR, PH_SMP_DATA
  } phase_t;

  phase_t                 phase;
  logic [LENGTH_BITS-1:0] offs;      // offset within current header
  logic [31:0]            acc;       // little-endian gather
  logic [7:0]             pattern_count, patterns_left;
  logic [6:0]             instrument_count, instruments_left;
  logic [15:0]            samples_left;
  logic [31:0]            ins_hdr_size, smp_hdr_size;
  logic [LENGTH_BITS-1:0] smp_sum, skip_left, consumed;
  logic                   name_term, weak_ver;

  // next-state copies
  phase_t                 phase_n;
  logic [LENGTH_BITS-1:0] offs_n, smp_sum_n, skip_n, consumed_n;
  logic [31:0]            acc_n, ins_n, smpsz_n;
  logic [7:0]             pc_n, pl_n;
  logic [6:0]             ic_n, il_n;
  logic [15:0]            sl_n;
  logic                   nt_n, weak_n;
  logic                   reject, done, emit;
  logic [31:0]            full;      // gathered field including this byte
  logic [1:0]             pos;
  logic [7:0]             b;
  logic [LENGTH_BITS:0]   sum_w;
  logic [LENGTH_BITS-1:0] o1;

  assign q_ready = !v_valid || v_ready;
  wire go = q_valid && q_ready;

  always_comb begin
    b = q_req.data_byte;
    phase_n = phase; offs_n = offs; acc_n = acc; pc_n = pattern_count;
    ic_n = instrument_count; pl_n = patterns_left; il_n = instruments_left;
    sl_n = samples_left; ins_n = ins_hdr_size; smpsz_n = smp_hdr_size;
    smp_sum_n = smp_sum; skip_n = skip_left; consumed_n = consumed;
    nt_n = name_term; weak_n = weak_ver;
    reject = 1'b0; done = 1'b0; pos = 2'd0; full = 32'd0; sum_w = '0;
    if (q_req.first) begin
      phase_n = PH_HEADER; offs_n = '0; acc_n = '0; pc_n = '0; ic_n = '0;
      pl_n = '0; il_n = '0; sl_n = '0; ins_n = '0; smpsz_n = '0;
      smp_sum_n = '0; skip_n = '0; consumed_n = '0; nt_n = 1'b0; weak_n = 1'b0;
    end
    o1 = offs_n + 1'b1;
    if (phase_n != PH_IDLE) begin
      if (consumed_n != LEN_MAX) consumed_n = consumed_n + 1'b1;
      unique case (phase_n)
        PH_HEADER: begin
          if (offs_n < 17) begin
            if (b != xmlp_pkg::sig_char(offs_n[4:0])) reject = 1'b1;
          end else if (offs_n < 37 || (offs_n > 37 && offs_n < 58)) begin
            if (offs_n == 17 || offs_n == 38) nt_n = 1'b0;
            if (!nt_n) begin
              if (b == 8'd0) nt_n = 1'b1;
              else if (b < 8'd32 || b > 8'd127) reject = 1'b1;
            end
          end else if (offs_n == 37) begin
            if (b != 8'h1a) reject = 1'b1;
          end else if (offs_n == 58 || offs_n == 70 || offs_n == 72) begin
            acc_n = {24'd0, b};
          end else if (offs_n == 59) begin
            weak_n = ({b, acc_n[7:0]} != 16'h0104);
          end else if (offs_n == 71) begin
            if (b != 8'd0) reject = 1'b1; else pc_n = acc_n[7:0];
          end else if (offs_n == 73) begin
            if (b != 8'd0 || acc_n[7]) reject = 1'b1; else ic_n = acc_n[6:0];
          end
          offs_n = o1;
          if (!reject && o1 == xmlp_pkg::HDR_BYTES) begin
            pl_n = pc_n; il_n = ic_n;
            if (pl_n != 0) begin pl_n = pl_n - 1'b1; phase_n = PH_PAT_HDR; offs_n = '0; end
            else if (il_n != 0) begin
              il_n = il_n - 1'b1; phase_n = PH_INS_HDR; offs_n = '0; smp_sum_n = '0;
            end else done = 1'b1;
          end
        end
        PH_PAT_HDR: begin
          if (offs_n == 0) acc_n = '0;
          pos = offs_n[1:0] - (offs_n >= 7 ? 2'd3 : 2'd0);
          if (offs_n < 4 || offs_n >= 7) begin
            full = acc_n | ({24'd0, b} << {pos, 3'b000});
            acc_n = full;
          end
          if (offs_n == 3 && full != xmlp_pkg::PAT_HDR_BYTES) reject = 1'b1;
          if (offs_n == 4 && b != 8'd0) reject = 1'b1;
          if (offs_n == 6) acc_n = '0;
          if (offs_n == 8) skip_n = LENGTH_BITS'(full[15:0]);
          offs_n = o1;
          if (!reject && o1 == xmlp_pkg::PAT_HDR_BYTES) begin
            if (skip_n != 0) phase_n = PH_PAT_DATA;
            else if (pl_n != 0) begin pl_n = pl_n - 1'b1; phase_n = PH_PAT_HDR; offs_n = '0; end
            else if (il_n != 0) begin
              il_n = il_n - 1'b1; phase_n = PH_INS_HDR; offs_n = '0; smp_sum_n = '0;
            end else done = 1'b1;
          end
        end
        PH_INS_HDR, PH_SMP_HDR: begin
          if (offs_n == 0 || offs_n == 27 || offs_n == 29) acc_n = '0;
          pos = (offs_n < 4) ? offs_n[1:0] : (offs_n < 29 ? offs_n[1:0] - 2'd3
                                                         : offs_n[1:0] - 2'd1);
          full = acc_n | ({24'd0, b} << {pos, 3'b000});
          if (offs_n < 4 || (phase_n == PH_INS_HDR && offs_n >= 27 && offs_n <= 32))
            acc_n = full;
          if (phase_n == PH_INS_HDR) begin
            if (offs_n == 3) begin ins_n = full; if (full < 29) reject = 1'b1; end
            if (offs_n == 28) begin
              sl_n = full[15:0]; smpsz_n = '0;
              if (sl_n != 0 && ins_n < 33) reject = 1'b1;
            end
            if (offs_n == 32) begin
              smpsz_n = full; if (sl_n != 0 && full < 4) reject = 1'b1;
            end
          end else if (offs_n == 3) begin
            sum_w = {1'b0, smp_sum_n} + (LENGTH_BITS+1)'(full);
            smp_sum_n = sum_w[LENGTH_BITS] ? LEN_MAX : sum_w[LENGTH_BITS-1:0];
          end
          offs_n = o1;
          if (!reject && offs_n >= 4 &&
              o1 == LENGTH_BITS'(phase_n == PH_INS_HDR ? ins_n : smpsz_n)) begin
            if (sl_n != 0) begin sl_n = sl_n - 1'b1; phase_n = PH_SMP_HDR; offs_n = '0; end
            else if (smp_sum_n != 0) begin skip_n = smp_sum_n; phase_n = PH_SMP_DATA; end
            else if (il_n != 0) begin
              il_n = il_n - 1'b1; phase_n = PH_INS_HDR; offs_n = '0; smp_sum_n = '0;
            end else done = 1'b1;
          end
        end
        PH_PAT_DATA, PH_SMP_DATA: begin
          skip_n = skip_n - 1'b1;
          if (skip_n == 0) begin
            if (phase_n == PH_PAT_DATA && pl_n != 0) begin
              pl_n = pl_n - 1'b1; phase_n = PH_PAT_HDR; offs_n = '0;
            end else if (il_n != 0) begin
              il_n = il_n - 1'b1; phase_n = PH_INS_HDR; offs_n = '0; smp_sum_n = '0;
            end else done = 1'b1;
          end
        end
        default: ;
      endcase
    end
    emit = (phase_n != PH_IDLE) && (reject || done || q_req.last);
    if (emit) phase_n = PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      offs <= offs_n; acc <= acc_n; pattern_count <= pc_n; instrument_count <= ic_n;
      patterns_left <= pl_n; instruments_left <= il_n; samples_left <= sl_n;
      ins_hdr_size <= ins_n; smp_hdr_size <= smpsz_n; smp_sum <= smp_sum_n;
      skip_left <= skip_n; consumed <= consumed_n; name_term <= nt_n; weak_ver <= weak_n;
      if (emit) begin
        v_out.status <= reject ? xmlp_pkg::ST_REJECTED :
                        done ? (weak_n ? xmlp_pkg::ST_WEAK : xmlp_pkg::ST_STRONG)
                             : xmlp_pkg::ST_TRUNCATED;
        v_out.total_length <= (!done || reject) ? 32'd0 :
          ((LENGTH_BITS > 32 && (consumed_n >> 32) != 0) ? 32'hffff_ffff
                                                         : 32'(consumed_n));
      end
    end
    if (rst) begin
      phase <= PH_IDLE; v_valid <= 1'b0;
    end else begin
      if (go) phase <= phase_n;
      if (go && emit) v_valid <= 1'b1;
      else if (v_ready) v_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) (v_valid && !v_ready) |-> !q_ready)
    else $error("engine accepted while verdict stalled");
  assert property (@(posedge clk) disable iff (rst)
                   (v_valid && v_out.status != xmlp_pkg::ST_STRONG &&
                    v_out.status != xmlp_pkg::ST_WEAK) |-> v_out.total_length == 32'd0)
    else $error("length on failed verdict");
  assert property (@(posedge clk) disable iff (rst) (go && emit) |=> phase == PH_IDLE)
    else $error("not idle after verdict");

endmodule

// ===== rtl/xm_module_length_parser_top.sv =====
// Top level of the extended-module length parser.
// Depends on xmlp_pkg, xmlp_front, xmlp_engine.
//
// Usage:
//   s_axis_*: one file byte per request. tdata[7:0] = data_byte,
//     tuser[0] = first_of_candidate (starts a new parse, dropping any old one),
//     tlast = last_of_data (end of available buffer).
//   m_axis_*: at most one verdict per candidate. tdata[1:0] = status
//     (0 strong, 1 weak version, 2 rejected, 3 truncated), tdata[33:2] =
//     total_length (saturated, 0 unless accepted), tdata[39:34] zero.
// Throughput: one byte per cycle sustained while m_axis_tready is high. Each byte
//   costs one pass of the parse engine's per-byte update.
// Path: a verdict's deciding byte passes through the two-entry input queue,
//   then the engine's verdict register.
// Reset: rst (synchronous, active high) empties the queue and idles the
//   parser; bytes before a first_of_candidate mark are dropped silently.
// Stall: when m_axis_tready is low the held verdict stops the engine, the
//   queue fills, and s_axis_tready drops once the two-entry queue is full.
module xm_module_length_parser_top #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] first_of_candidate
  input  logic        s_axis_tlast,   // last_of_data
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [1:0] status, [33:2] total_length
);

  xmlp_pkg::byte_req_t in_req, q_req;
  xmlp_pkg::verdict_t  v_out;
  logic                q_valid, q_ready;

  assign in_req.data_byte = s_axis_tdata;
  assign in_req.first     = s_axis_tuser;
  assign in_req.last      = s_axis_tlast;

  xmlp_front u_front (
    .clk, .rst,
    .in_valid (s_axis_tvalid), .in_ready (s_axis_tready), .in_req,
    .q_valid, .q_ready, .q_req
  );

  xmlp_engine #(.LENGTH_BITS(LENGTH_BITS)) u_engine (
    .clk, .rst,
    .q_valid, .q_ready, .q_req,
    .v_valid (m_axis_tvalid), .v_ready (m_axis_tready), .v_out
  );

  assign m_axis_tdata = {6'd0, v_out.total_length, v_out.status};

endmodule
